/* rtl/core/dcdr_pkg.sv */
package dcdr_pkg;

  // Frequency words: unsigned counts of 1/16 Hz
  localparam int FREQ_BITS      = 18;
  localparam int STEP_BITS      = 16;
  localparam int CLAMP_BITS     = 18;
  localparam int TIMEOUT_BITS   = 16;
  localparam int OP_BITS        = 2;
  localparam int EVENT_BITS     = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 18;

  // Widths used for exact compares between differently sized words
  localparam int CMP_BITS  = (FREQ_BITS > CLAMP_BITS) ? FREQ_BITS : CLAMP_BITS;
  localparam int DIFF_BITS = (FREQ_BITS > STEP_BITS) ? FREQ_BITS : STEP_BITS;

  typedef logic [FREQ_BITS-1:0]    freq_t;
  typedef logic [STEP_BITS-1:0]    step_t;
  typedef logic [CLAMP_BITS-1:0]   clamp_t;
  typedef logic [TIMEOUT_BITS-1:0] ticks_t;
  typedef logic [OP_BITS-1:0]      op_t;
  typedef logic [EVENT_BITS-1:0]   event_t;

  // Opcodes
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_SET   = 2'd1;
  localparam op_t OP_STOP  = 2'd2;
  localparam op_t OP_OTHER = 2'd3;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX     = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = 2'd3;

  // Event codes
  localparam event_t EV_NONE      = 3'd0;
  localparam event_t EV_SET_OK    = 3'd1;
  localparam event_t EV_SET_REJ   = 3'd2;
  localparam event_t EV_STOP_REQ  = 3'd3;
  localparam event_t EV_STOPPED   = 3'd4;
  localparam event_t EV_TIMEOUT   = 3'd5;

  // Register reset values (1000 Hz and 10000 Hz clamps)
  localparam step_t  STEP_RESET    = STEP_BITS'(16);
  localparam clamp_t MIN_RESET     = CLAMP_BITS'(16000);
  localparam clamp_t MAX_RESET     = CLAMP_BITS'(160000);
  localparam ticks_t TIMEOUT_RESET = TIMEOUT_BITS'(500);
  localparam ticks_t IDLE_MAX      = {TIMEOUT_BITS{1'b1}};

  typedef struct packed {
    step_t  step_per_tick;
    clamp_t min_frequency;
    clamp_t max_frequency;
    ticks_t timeout_ticks;
  } cfg_t;

  typedef struct packed {
    freq_t  target_left;
    freq_t  target_right;
    freq_t  current_left;
    freq_t  current_right;
    logic   active_flag;
    logic   stop_flag;
    logic   command_seen;
    ticks_t idle_ticks;
  } state_t;

  // One slew-limited step of a channel toward its target
  function automatic freq_t approach(freq_t cur, freq_t tgt, step_t step);
    freq_t diff;
    logic  in_reach;
    diff     = (cur < tgt) ? (tgt - cur) : (cur - tgt);
    in_reach = DIFF_BITS'(diff) <= DIFF_BITS'(step);
    if (cur == tgt) begin
      return cur;
    end else if (in_reach) begin
      return tgt;
    end else if (cur < tgt) begin
      return cur + FREQ_BITS'(step);
    end else begin
      return cur - FREQ_BITS'(step);
    end
  endfunction

  // Lower clamp takes priority over the upper one
  function automatic freq_t clamp_freq(freq_t f, clamp_t lo, clamp_t hi);
    if (CMP_BITS'(f) < CMP_BITS'(lo)) begin
      return FREQ_BITS'(lo);
    end else if (CMP_BITS'(f) > CMP_BITS'(hi)) begin
      return FREQ_BITS'(hi);
    end else begin
      return f;
    end
  endfunction

endpackage

/* rtl/core/dcdr_update.sv */
module dcdr_update (
  input  dcdr_pkg::state_t cur,
  input  dcdr_pkg::cfg_t   cfg,
  input  dcdr_pkg::op_t    opcode,
  input  dcdr_pkg::freq_t  left_request,
  input  dcdr_pkg::freq_t  right_request,
  output dcdr_pkg::state_t nxt,
  output dcdr_pkg::event_t event_code
);
  import dcdr_pkg::*;

  state_t s;
  event_t ev;

  always_comb begin
    s  = cur;
    ev = EV_NONE;
    unique case (opcode)
      OP_TICK: begin
        // ramp both channels, then check for the end of a pending stop
        if (s.active_flag && (cfg.step_per_tick != '0)) begin
          s.current_left  = approach(s.current_left, s.target_left, cfg.step_per_tick);
          s.current_right = approach(s.current_right, s.target_right, cfg.step_per_tick);
          if (s.stop_flag && (s.current_left == s.target_left) &&
              (s.current_right == s.target_right)) begin
            s.target_left   = '0;
            s.target_right  = '0;
            s.current_left  = '0;
            s.current_right = '0;
            s.active_flag   = 1'b0;
            s.stop_flag     = 1'b0;
            ev              = EV_STOPPED;
          end
        end
        // watchdog, saturating
        if (s.idle_ticks != IDLE_MAX) begin
          s.idle_ticks = s.idle_ticks + TIMEOUT_BITS'(1);
        end
        if (s.command_seen && (cfg.timeout_ticks != '0) && s.active_flag &&
            (s.idle_ticks >= cfg.timeout_ticks)) begin
          s.target_left  = '0;
          s.target_right = '0;
          s.stop_flag    = 1'b1;
          s.command_seen = 1'b0;
          ev             = EV_TIMEOUT;
        end
      end
      OP_SET: begin
        s.command_seen = 1'b1;
        s.idle_ticks   = '0;
        if ((left_request == '0) || (right_request == '0)) begin
          ev = EV_SET_REJ;
        end else begin
          s.target_left  = clamp_freq(left_request, cfg.min_frequency, cfg.max_frequency);
          s.target_right = clamp_freq(right_request, cfg.min_frequency, cfg.max_frequency);
          s.active_flag  = 1'b1;
          s.stop_flag    = 1'b0;
          ev             = EV_SET_OK;
        end
      end
      OP_STOP: begin
        s.command_seen = 1'b1;
        s.idle_ticks   = '0;
        s.target_left  = '0;
        s.target_right = '0;
        if (s.active_flag) begin
          s.stop_flag = 1'b1;
          ev          = EV_STOP_REQ;
        end else begin
          // nothing running: clear everything at once
          s.current_left  = '0;
          s.current_right = '0;
          s.stop_flag     = 1'b0;
          ev              = EV_STOPPED;
        end
      end
      OP_OTHER: begin
        // keepalive only
        s.command_seen = 1'b1;
        s.idle_ticks   = '0;
      end
      default: begin
        s = cur;
      end
    endcase
  end

  assign nxt        = s;
  assign event_code = ev;

endmodule

/* rtl/core/dual_channel_drive_ramp.sv */
// Channel   Handshake               Payload
// command   cmd_valid / cmd_stall   opcode, left_request, right_request
// result    res_valid / res_stall   left_drive, right_drive, motors_off,
//                                   drive_active, stop_pending, event_code
// config    cfg_we                  cfg_index, cfg_data
//
// One transaction per cycle sustained while the result is not stalled; a command
// passes from the input register to the result register once that is free.
// The rate is set by the state update loop, which closes through the state register.
// Reset (rst, synchronous) loads register defaults and clears all drive state.
// A stalled result holds while one further command waits in the input register.
module dual_channel_drive_ramp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_stall,
  input  dcdr_pkg::op_t                         opcode,
  input  dcdr_pkg::freq_t                       left_request,
  input  dcdr_pkg::freq_t                       right_request,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output dcdr_pkg::freq_t                       left_drive,
  output dcdr_pkg::freq_t                       right_drive,
  output logic                                  motors_off,
  output logic                                  drive_active,
  output logic                                  stop_pending,
  output dcdr_pkg::event_t                      event_code,
  input  logic                                  cfg_we,
  input  logic [dcdr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dcdr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import dcdr_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  event_t event_next;

  logic   in_full;
  op_t    in_opcode;
  freq_t  in_left;
  freq_t  in_right;
  logic   advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_per_tick <= STEP_RESET;
      cfg.min_frequency <= MIN_RESET;
      cfg.max_frequency <= MAX_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP:    cfg.step_per_tick <= cfg_data[STEP_BITS-1:0];
        REG_MIN:     cfg.min_frequency <= cfg_data[CLAMP_BITS-1:0];
        REG_MAX:     cfg.max_frequency <= cfg_data[CLAMP_BITS-1:0];
        REG_TIMEOUT: cfg.timeout_ticks <= cfg_data[TIMEOUT_BITS-1:0];
        default:     cfg.step_per_tick <= cfg.step_per_tick;
      endcase
    end
  end

  // input register moves on whenever the result register is free
  assign advance   = in_full && (!res_valid || !res_stall);
  assign cmd_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_opcode <= opcode;
      in_left   <= left_request;
      in_right  <= right_request;
    end
  end

  // next-state logic
  dcdr_update u_update (
    .cur           (state),
    .cfg           (cfg),
    .opcode        (in_opcode),
    .left_request  (in_left),
    .right_request (in_right),
    .nxt           (state_next),
    .event_code    (event_next)
  );

  // drive state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_drive   <= state_next.current_left;
      right_drive  <= state_next.current_right;
      motors_off   <= (state_next.current_left == '0) && (state_next.current_right == '0);
      drive_active <= state_next.active_flag;
      stop_pending <= state_next.stop_flag;
      event_code   <= event_next;
    end
  end

endmodule

/* rtl/core/dcdr_checker.sv */
module dcdr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                res_valid,
  input logic                                res_stall,
  input dcdr_pkg::freq_t                     left_drive,
  input dcdr_pkg::freq_t                     right_drive,
  input logic                                motors_off,
  input logic                                drive_active,
  input logic                                stop_pending,
  input dcdr_pkg::event_t                    event_code
);
  import dcdr_pkg::*;

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result dropped while stalled");

  // motors_off agrees with both drive values
  a_off_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (motors_off == ((left_drive == '0) && (right_drive == '0))))
    else $error("motors_off inconsistent with drive values");

  // a pending stop only exists while the drive runs
  a_stop_active: assert property (@(posedge clk) disable iff (rst)
    res_valid && stop_pending |-> drive_active)
    else $error("stop pending without active drive");

  // a completed stop leaves the motors at rest and the drive off
  a_stopped_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_code == EV_STOPPED) |-> (motors_off && !drive_active && !stop_pending))
    else $error("stop event with drive still running");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind dual_channel_drive_ramp dcdr_checker u_dcdr_checker (.*);
